>>> design/xcfd_pkg.sv
// Shared types and constants for the XOR-checked frame deframer.
package xcfd_pkg;

  // Value the start marker register takes at reset
  localparam logic [7:0] StartMarkerReset = 8'hAA;

  // Deframer phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // Result item kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  command_code;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [31:0] first_word;
    logic        frame_end;
  } result_t;

endpackage

>>> design/xor_checked_frame_deframer_unit.sv
// Top level of the XOR-checked frame deframer.
// A result item appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while the result side keeps taking items.
// The byte update is one pass through the parser into the result register.
// Reset (rst, synchronous, active high) sets hunting, clears frame state and
// loads the start marker with 0xAA.
module xor_checked_frame_deframer_unit
  import xcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  item_kind,
  output logic [7:0]  command_code,
  output logic [7:0]  payload_byte,
  output logic [7:0]  byte_index,
  output logic [7:0]  frame_length,
  output logic [31:0] first_word,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] start_marker;
  logic       step;
  logic       res_valid;
  logic       free;
  result_t    res;
  result_t    data;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= StartMarkerReset;
    end else if (cfg_valid) begin
      start_marker <= cfg_data;
    end
  end

  assign in_ready = free;
  assign step     = in_valid && free;

  xcfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (rx_byte),
    .start_marker (start_marker),
    .res_valid    (res_valid),
    .res          (res)
  );

  xcfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .data      (data)
  );

  // Result fields
  assign item_kind    = data.item_kind;
  assign command_code = data.command_code;
  assign payload_byte = data.payload_byte;
  assign byte_index   = data.byte_index;
  assign frame_length = data.frame_length;
  assign first_word   = data.first_word;
  assign frame_end    = data.frame_end;

endmodule

>>> design/xcfd_parser.sv
// Frame parser: phase machine, running checksum and payload word gathering.
module xcfd_parser
  import xcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  start_marker,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [31:0] word_accumulator, word_accumulator_next;
  logic [31:0] word_merged;

  // Payload byte merged into the little-endian word (first four bytes only)
  always_comb begin
    word_merged = word_accumulator;
    if (payload_count[7:2] == 6'd0) begin
      unique case (payload_count[1:0])
        2'd0: word_merged[7:0]   = word_accumulator[7:0]   | rx_byte;
        2'd1: word_merged[15:8]  = word_accumulator[15:8]  | rx_byte;
        2'd2: word_merged[23:16] = word_accumulator[23:16] | rx_byte;
        2'd3: word_merged[31:24] = word_accumulator[31:24] | rx_byte;
        default: word_merged = word_accumulator;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_CMD:     phase_next = PH_LEN;
        PH_LEN:     phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        PH_PAYLOAD: phase_next = (payload_count + 8'd1 == held_length) ? PH_CHECK
                                                                       : PH_PAYLOAD;
        PH_CHECK:   phase_next = PH_HUNT;
        default:    phase_next = (rx_byte == start_marker) ? PH_CMD : PH_HUNT;
      endcase
    end
  end

  // Frame state updates and result item
  always_comb begin
    held_command_next     = held_command;
    held_length_next      = held_length;
    payload_count_next    = payload_count;
    running_xor_next      = running_xor;
    word_accumulator_next = word_accumulator;
    res_valid             = 1'b0;
    res.item_kind         = KIND_PAYLOAD;
    res.command_code      = held_command;
    res.payload_byte      = 8'd0;
    res.byte_index        = 8'd0;
    res.frame_length      = held_length;
    res.first_word        = word_accumulator;
    res.frame_end         = 1'b0;
    if (step) begin
      unique case (phase)
        PH_CMD: begin
          held_command_next = rx_byte;
          running_xor_next  = running_xor ^ rx_byte;
        end
        PH_LEN: begin
          held_length_next      = rx_byte;
          running_xor_next      = running_xor ^ rx_byte;
          payload_count_next    = 8'd0;
          word_accumulator_next = 32'd0;
        end
        PH_PAYLOAD: begin
          word_accumulator_next = word_merged;
          running_xor_next      = running_xor ^ rx_byte;
          payload_count_next    = payload_count + 8'd1;
          res_valid             = 1'b1;
          res.payload_byte      = rx_byte;
          res.byte_index        = payload_count;
          res.first_word        = word_merged;
        end
        PH_CHECK: begin
          res_valid     = 1'b1;
          res.item_kind = (rx_byte == running_xor) ? KIND_ACCEPTED : KIND_MISMATCH;
          res.frame_end = 1'b1;
        end
        default: begin
          if (rx_byte == start_marker) running_xor_next = rx_byte;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      held_command     <= 8'd0;
      held_length      <= 8'd0;
      payload_count    <= 8'd0;
      running_xor      <= 8'd0;
      word_accumulator <= 32'd0;
    end else begin
      phase            <= phase_next;
      held_command     <= held_command_next;
      held_length      <= held_length_next;
      payload_count    <= payload_count_next;
      running_xor      <= running_xor_next;
      word_accumulator <= word_accumulator_next;
    end
  end

  // Zero-length frame goes straight to the checksum byte
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_LEN && rx_byte == 8'd0) |=> phase == PH_CHECK)
    else $error("zero-length frame did not go to checksum");

  // Checksum byte always returns to hunting
  a_check_hunt: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_CHECK) |=> phase == PH_HUNT)
    else $error("checksum byte did not end the frame");

  // Each payload item advances the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_PAYLOAD) |=> payload_count == $past(payload_count) + 8'd1)
    else $error("payload count did not advance");

  // No item, no change of phase
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase))
    else $error("phase moved without an item");

endmodule

>>> design/xcfd_out_reg.sv
// Result register between the parser and the output channel.
module xcfd_out_reg
  import xcfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    free,
  output result_t data
);

  // Slot is free when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data <= res;
    end
  end

endmodule

>>> verif/xcfd_frame_checker.sv
// Checker for the XOR-checked frame deframer: tracks the byte stream and compares result items.
module xcfd_frame_checker
  import xcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  item_kind,
  input  logic [7:0]  command_code,
  input  logic [7:0]  payload_byte,
  input  logic [7:0]  byte_index,
  input  logic [7:0]  frame_length,
  input  logic [31:0] first_word,
  input  logic        frame_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the deframer state
  logic [7:0]  marker_q;
  phase_t      phase_q;
  logic [7:0]  cmd_q;
  logic [7:0]  len_q;
  logic [7:0]  count_q;
  logic [7:0]  xor_q;
  logic [31:0] word_q;

  // Result items still owed by the block, oldest first
  result_t results_due[$];
  int      mismatch_count = 0;
  int      due_count = 0;

  assign fail_count    = mismatch_count;
  assign pending_count = due_count;

  // Advance the shadow state by one received byte; queue any result item
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] idx;
    result_t    r;
    r = '0;
    case (phase_q)
      PH_CMD: begin
        cmd_q   = b;
        xor_q   = xor_q ^ b;
        phase_q = PH_LEN;
      end
      PH_LEN: begin
        len_q   = b;
        xor_q   = xor_q ^ b;
        count_q = 8'd0;
        word_q  = 32'd0;
        if (b == 8'd0) begin
          phase_q = PH_CHECK;
        end else begin
          phase_q = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        idx = count_q;
        if (idx < 8'd4) begin
          word_q = word_q | (32'(b) << (8 * idx));
        end
        xor_q   = xor_q ^ b;
        count_q = idx + 8'd1;
        if (count_q == len_q) begin
          phase_q = PH_CHECK;
        end
        r.item_kind    = KIND_PAYLOAD;
        r.command_code = cmd_q;
        r.payload_byte = b;
        r.byte_index   = idx;
        r.frame_length = len_q;
        r.first_word   = word_q;
        r.frame_end    = 1'b0;
        results_due.push_back(r);
      end
      PH_CHECK: begin
        // closing item: checksum verdict, header and gathered word
        r.item_kind    = (b == xor_q) ? KIND_ACCEPTED : KIND_MISMATCH;
        r.command_code = cmd_q;
        r.frame_length = len_q;
        r.first_word   = word_q;
        r.frame_end    = 1'b1;
        results_due.push_back(r);
        phase_q = PH_HUNT;
      end
      default: begin
        // hunting: anything but the marker is dropped
        phase_q = PH_HUNT;
        if (b == marker_q) begin
          xor_q   = b;
          phase_q = PH_CMD;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sample all three channels on the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      marker_q = StartMarkerReset;
      phase_q  = PH_HUNT;
      cmd_q    = 8'd0;
      len_q    = 8'd0;
      count_q  = 8'd0;
      xor_q    = 8'd0;
      word_q   = 32'd0;
      results_due.delete();
    end else begin
      // a result is registered before it can leave, so check before predicting
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display({"%0t: result item with none expected: expected none, ",
                    "got kind %0d cmd 0x%0h byte 0x%0h index %0d ",
                    "length %0d word 0x%0h end %0b"},
                   $time, item_kind, command_code, payload_byte, byte_index,
                   frame_length, first_word, frame_end);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(item_kind));
          check_field("command_code", 32'(want.command_code), 32'(command_code));
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
          check_field("byte_index", 32'(want.byte_index), 32'(byte_index));
          check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
          check_field("first_word", want.first_word, first_word);
          check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
        end
      end
      if (cfg_valid && cfg_ready) begin
        marker_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
      end
    end
    due_count = results_due.size();
  end

endmodule

>>> verif/xor_checked_frame_deframer_unit_tb.sv
// Testbench top for the XOR-checked frame deframer: stimulus, back-pressure and verdict.
module xor_checked_frame_deframer_unit_tb;
  import xcfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  item_kind;
  logic [7:0]  command_code;
  logic [7:0]  payload_byte;
  logic [7:0]  byte_index;
  logic [7:0]  frame_length;
  logic [31:0] first_word;
  logic        frame_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;

  int         fail_count;
  int         pending_count;
  logic [7:0] marker = StartMarkerReset;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         items_sent = 0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  xor_checked_frame_deframer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .command_code (command_code),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .first_word   (first_word),
    .frame_end    (frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  xcfd_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .command_code  (command_code),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .frame_length  (frame_length),
    .first_word    (first_word),
    .frame_end     (frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Result side: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    logic ready_next;
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_ready <= ready_next;
  end

  // Watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("xor_checked_frame_deframer_unit: mismatch");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until taken; leaves valid high unless a gap follows
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and let every owed result drain, then allow for latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_marker(input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    marker = value;
  endtask

  // Whole frame with the current marker; optionally spoil the checksum
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] body[$],
                            input bit corrupt);
    logic [7:0] sum;
    sum = marker ^ cmd ^ 8'(body.size());
    send_byte(marker);
    send_byte(cmd);
    send_byte(8'(body.size()));
    foreach (body[i]) begin
      sum = sum ^ body[i];
      send_byte(body[i]);
    end
    if (corrupt) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_byte(sum);
    items_sent += body.size() + 4;
  endtask

  // Mostly well-formed frames, some bad checksums, truncated frames and line noise
  task automatic frame_traffic(input int n);
    int         target;
    int         pick;
    int         len;
    int         cut;
    logic [7:0] body[$];
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 49) == 0) begin
        len = $urandom_range(9, 64);
      end else if ($urandom_range(0, 15) == 0) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 8);
      end
      body.delete();
      for (int i = 0; i < len; i++) body.push_back(8'($urandom));
      if (pick < 2) begin
        // noise on the line, mostly dropped while hunting
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick == 2) begin
        // frame cut short; following bytes are swallowed by it
        cut = $urandom_range(0, (len > 0) ? len - 1 : 0);
        send_byte(marker);
        send_byte(8'($urandom));
        send_byte(8'(len));
        for (int i = 0; i < cut; i++) send_byte(body[i]);
        items_sent += cut + 3;
      end else begin
        send_frame(8'($urandom), body, pick < 5);
      end
    end
  endtask

  initial begin
    logic [7:0] body[$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: noise while hunting, zero length, extremes, marker as data, bad checksums
    send_byte(8'h00);
    send_byte(8'hFF);
    body.delete();
    send_frame(8'hFF, body, 1'b0);
    body = '{8'hFF, 8'h00, StartMarkerReset, 8'h55, 8'h80};
    send_frame(8'h00, body, 1'b0);
    body = '{8'h7F};
    send_frame(8'h5A, body, 1'b1);
    body.delete();
    send_frame(8'h3C, body, 1'b1);

    write_marker(8'h00);
    frame_traffic(150);

    // longest frame against a long result hold-off, then a full drain
    write_marker(8'hFF);
    body.delete();
    for (int i = 0; i < 255; i++) body.push_back(8'($urandom));
    hold_req = 1'b1;
    send_frame(8'($urandom), body, 1'b0);
    wait_drained();
    frame_traffic(140);

    write_marker(8'($urandom_range(1, 254)));
    frame_traffic(140);

    write_marker(StartMarkerReset);
    frame_traffic(40);
    quiet = 1'b1;
    frame_traffic(100);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("xor_checked_frame_deframer_unit: match");
    end else begin
      $display("xor_checked_frame_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/xcfd_pkg.sv
design/xcfd_parser.sv
design/xcfd_out_reg.sv
design/xor_checked_frame_deframer_unit.sv
verif/xcfd_frame_checker.sv
verif/xor_checked_frame_deframer_unit_tb.sv
